>>> hdl/fbfl_pkg.sv
// Package for the fixed block free list allocator.
// Holds the command and status codes, field widths and reset values.
// No dependencies.
`default_nettype none

package fbfl_pkg;

   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   localparam int LINK_W = 9;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   localparam int MAX_BLOCKS_DEFAULT = 256;
   localparam int LINK_DEPTH_CAP = 256;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;
   localparam logic [LINK_W-1:0] LINK_NONE = 9'h100;

   localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

`default_nettype wire

>>> hdl/fixed_block_free_list_allocator.sv
// Fixed block free list allocator: command decode, pool state and link memory.
// Depends on fbfl_pkg for codes, widths and reset values.
//
// Usage: each request word on req_ is a command (init, alloc or free) and gives
// exactly one response word on rsp_, in order. Init makes blocks 0 up to
// block_count-1 (block_count capped at MAX_BLOCKS) free and hands them out in ascending order;
// alloc pops the most recently freed block first; free pushes a block onto the list.
// Every response carries the free block count after the command.
// block_count is written through csr_wr_en/csr_wr_data while no command is
// outstanding; it takes effect at the next command.
// The response is registered and valid in the cycle after acceptance.
// One command per cycle is accepted for init, free and alloc of an untouched block
// while the response is taken; an alloc that pops the free list holds off the next
// command while the new head is read from the link memory, whose read is registered.
// When rsp_tready is low the response waits in its register and req_tready
// drops until it is taken; a new command is accepted in the cycle the waiting
// word leaves.
// Reset empties the pool (no free blocks, list empty) and sets block_count to
// 256. The link memory is not cleared: an entry is always written by a free
// before the list can point at it.
`default_nettype none

module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // csr_wr_data: block_count[8:0]
   input  wire                                   csr_wr_en,
   input  wire  [fbfl_pkg::COUNT_W-1:0]          csr_wr_data,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // req_tdata: block_index[7:0], block_present[8], zero pad[15:9]
   input  wire  [fbfl_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_tuser: kind[1:0]
   input  wire  [fbfl_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // rsp_tdata: granted_block[7:0], granted[8], free_count[17:9],
   //            status[19:18], zero pad[23:20]
   output logic [fbfl_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   import fbfl_pkg::*;

   // Only indexes below MAX_BLOCKS and below 256 can be freed, so the link memory is as deep as the smaller.
   localparam int LinkDepth = (MAX_BLOCKS < LINK_DEPTH_CAP) ? MAX_BLOCKS : LINK_DEPTH_CAP;
   localparam int AddrW = $clog2(LinkDepth);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP = 1'b1;

   logic                state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  mark_ff, mark_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  count_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [LINK_W-1:0]   link_mem [LinkDepth];
   logic [LINK_W-1:0]   rd_data_ff;
   logic                rd_en;
   logic                wr_en;
   logic [AddrW-1:0]    rd_addr;
   logic [AddrW-1:0]    wr_addr;
   logic [LINK_W-1:0]   wr_data;

   logic                accept;
   logic [KIND_W-1:0]   kind;
   logic [INDEX_W-1:0]  blk_idx;
   logic                blk_present;
   logic                head_valid;
   logic                over_max;
   logic [COUNT_W-1:0]  pool_limit;

   logic [INDEX_W-1:0]  grant_blk;
   logic                grant;
   logic [STATUS_W-1:0] status;

   assign kind        = req_tuser[KIND_W-1:0];
   assign blk_idx     = req_tdata[INDEX_W-1:0];
   assign blk_present = req_tdata[INDEX_W];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // The head only ever holds a freed index or the none marker.
   assign head_valid = !head_ff[LINK_W-1];

   assign over_max   = 32'(count_ff) > 32'(MAX_BLOCKS);
   assign pool_limit = over_max ? COUNT_W'(MAX_BLOCKS) : count_ff;

   assign rd_addr = head_ff[AddrW-1:0];
   assign wr_addr = blk_idx[AddrW-1:0];

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      mark_in   = mark_ff;
      total_in  = total_ff;
      grant_blk = '0;
      grant     = 1'b0;
      status    = STATUS_OK;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_data   = head_valid ? head_ff : LINK_NONE;

      if (state_ff == S_POP) begin
         // Link of the popped block arrives from memory this cycle.
         head_in  = rd_data_ff;
         state_in = S_IDLE;
      end else if (accept) begin
         unique case (kind)
            KIND_INIT: begin
               head_in  = LINK_NONE;
               mark_in  = '0;
               total_in = pool_limit;
            end
            KIND_ALLOC: begin
               if (head_valid) begin
                  grant_blk = head_ff[INDEX_W-1:0];
                  grant     = 1'b1;
                  rd_en     = 1'b1;
                  state_in  = S_POP;
                  if (total_ff != '0) begin
                     total_in = total_ff - 1'b1;
                  end
               end else if ((total_ff != '0) && (mark_ff < pool_limit)) begin
                  grant_blk = mark_ff[INDEX_W-1:0];
                  grant     = 1'b1;
                  mark_in   = mark_ff + 1'b1;
                  total_in  = total_ff - 1'b1;
               end else begin
                  status = STATUS_EMPTY;
               end
            end
            KIND_FREE: begin
               if (blk_present) begin
                  if ({1'b0, blk_idx} >= pool_limit) begin
                     status = STATUS_RANGE;
                  end else begin
                     wr_en   = 1'b1;
                     head_in = {1'b0, blk_idx};
                     if (total_ff != COUNT_MAX) begin
                        total_in = total_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= LINK_NONE;
         mark_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= BLOCK_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         mark_ff      <= mark_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {{(RSP_DATA_W - INDEX_W - 1 - COUNT_W - STATUS_W){1'b0}},
                         status, total_in, grant, grant_blk};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // No command may enter while the popped head is still being fetched.
   a_pop_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> !req_tready)
      else $error("command accepted during list pop");

   // An alloc that takes the list head always enters the pop state to fetch the link.
   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == KIND_ALLOC) && head_valid) |=> (state_ff == S_POP))
      else $error("list pop did not fetch the next link");

   // A granted block never comes with an error status.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[INDEX_W]) |->
         (rsp_data_ff[INDEX_W+1+COUNT_W +: STATUS_W] == STATUS_OK))
      else $error("grant reported with nonzero status");

   // A free that is pushed leaves the freed block at the head of the list.
   a_push_head: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (head_ff == {1'b0, $past(blk_idx)}))
      else $error("freed block is not the new head");
`endif

endmodule

`default_nettype wire

>>> dv/tb_fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
// Testbench for fixed_block_free_list_allocator: directed and random command streams,
// each response word checked field by field against an in-bench model of the pool.
// Depends on fbfl_pkg and the allocator RTL.

module tb_fixed_block_free_list_allocator;
   import fbfl_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_SHOWN = 10;
   localparam int RANDOM_PHASE_ITEMS = 60;

   typedef struct packed {
      logic [3:0]          pad;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_count;
      logic                granted;
      logic [INDEX_W-1:0]  granted_block;
   } pool_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Model of the pool, updated at each accepted command word.
   logic [COUNT_W-1:0]    pool_size = BLOCK_COUNT_RESET;
   logic [LINK_W-1:0]     list_head = LINK_NONE;
   logic [COUNT_W-1:0]    untouched_next = '0;
   logic [COUNT_W-1:0]    free_blocks = '0;
   logic [LINK_W-1:0]     block_links [MAX_BLOCKS_DEFAULT];

   pool_result_type       awaited_results [$];
   logic [INDEX_W-1:0]    held_blocks [$];
   int                    mismatches = 0;
   int                    quiet_cycles = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   bit                    hold_rsp = 1'b0;

   fixed_block_free_list_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic pool_result_type predict_command(logic [KIND_W-1:0] kind,
                                                        logic [INDEX_W-1:0] index,
                                                        logic present);
      pool_result_type res;
      logic [COUNT_W-1:0] limit;
      res = '0;
      limit = (pool_size > COUNT_W'(MAX_BLOCKS_DEFAULT)) ? COUNT_W'(MAX_BLOCKS_DEFAULT)
                                                          : pool_size;
      case (kind)
         KIND_INIT: begin
            list_head = LINK_NONE;
            untouched_next = '0;
            free_blocks = limit;
         end
         KIND_ALLOC: begin
            // The free list is popped whenever it holds a block, even if the count is zero.
            if (!list_head[LINK_W-1]) begin
               res.granted_block = list_head[INDEX_W-1:0];
               res.granted = 1'b1;
               list_head = block_links[list_head[INDEX_W-1:0]];
               if (free_blocks != '0) free_blocks = free_blocks - 1'b1;
            end else if (free_blocks != '0 && untouched_next < limit) begin
               res.granted_block = untouched_next[INDEX_W-1:0];
               res.granted = 1'b1;
               untouched_next = untouched_next + 1'b1;
               free_blocks = free_blocks - 1'b1;
            end else begin
               res.status = STATUS_EMPTY;
            end
         end
         KIND_FREE: begin
            if (present) begin
               if ({1'b0, index} >= limit) begin
                  res.status = STATUS_RANGE;
               end else begin
                  block_links[index] = list_head[LINK_W-1] ? LINK_NONE : list_head;
                  list_head = {1'b0, index};
                  if (free_blocks != COUNT_MAX) free_blocks = free_blocks + 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.free_count = free_blocks;
      return res;
   endfunction

   task automatic note_failure(string what);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (want !== got) note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   // Responses are checked before the command of the same edge is predicted.
   always @(posedge clock) begin : result_check
      pool_result_type seen;
      pool_result_type want;
      if (reset) begin
         pool_size = BLOCK_COUNT_RESET;
         list_head = LINK_NONE;
         untouched_next = '0;
         free_blocks = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("response word %h with nothing expected", rsp_tdata));
            end else begin
               want = awaited_results.pop_front();
               compare_field("granted_block", COUNT_W'(want.granted_block),
                             COUNT_W'(seen.granted_block));
               compare_field("granted", COUNT_W'(want.granted), COUNT_W'(seen.granted));
               compare_field("free_count", want.free_count, seen.free_count);
               compare_field("status", COUNT_W'(want.status), COUNT_W'(seen.status));
               compare_field("pad", COUNT_W'(want.pad), COUNT_W'(seen.pad));
            end
         end
         if (csr_wr_en) pool_size = csr_wr_data;
         if (req_tvalid && req_tready) begin
            want = predict_command(req_tuser, req_tdata[INDEX_W-1:0], req_tdata[INDEX_W]);
            awaited_results.push_back(want);
            if (want.granted) held_blocks.push_back(want.granted_block);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_ready_drive
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Leaves tvalid high after the handshake so back-to-back words need no extra edge.
   task automatic send_command(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index,
                               logic present);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (kind == KIND_INIT) held_blocks.delete();
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, present, index};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0 || rsp_tvalid);
   endtask

   task automatic write_block_count(logic [COUNT_W-1:0] value);
      wait_for_results();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_before_init();
      set_idling(0, 0);
      send_command(KIND_ALLOC, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd5, 1'b1);
      send_command(KIND_ALLOC, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd255, 1'b0);
      send_command(KIND_UNUSED, 8'd255, 1'b1);
   endtask

   task automatic test_small_pool();
      write_block_count(9'd3);
      send_command(KIND_INIT, 8'd0, 1'b0);
      repeat (4) send_command(KIND_ALLOC, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd3, 1'b1);
      send_command(KIND_FREE, 8'd1, 1'b1);
      send_command(KIND_FREE, 8'd2, 1'b1);
      send_command(KIND_ALLOC, 8'd0, 1'b0);
      // A double free links block 0 to itself, so it is granted over and over.
      send_command(KIND_FREE, 8'd0, 1'b1);
      send_command(KIND_FREE, 8'd0, 1'b1);
      repeat (2) send_command(KIND_ALLOC, 8'd0, 1'b0);
   endtask

   task automatic test_pool_extremes();
      write_block_count(9'd0);
      send_command(KIND_INIT, 8'd255, 1'b1);
      send_command(KIND_ALLOC, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd0, 1'b1);
      // Anything above the block limit is clamped to it.
      write_block_count(9'd511);
      send_command(KIND_INIT, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd255, 1'b1);
      repeat (2) send_command(KIND_ALLOC, 8'd0, 1'b0);
      write_block_count(9'd1);
      send_command(KIND_INIT, 8'd0, 1'b0);
      repeat (2) send_command(KIND_ALLOC, 8'd0, 1'b0);
      send_command(KIND_FREE, 8'd0, 1'b1);
   endtask

   task automatic test_count_saturation();
      set_idling(28, 28);
      write_block_count(9'd256);
      send_command(KIND_INIT, 8'd0, 1'b0);
      repeat (258) send_command(KIND_FREE, INDEX_W'($urandom_range(255)), 1'b1);
      repeat (4) send_command(KIND_ALLOC, INDEX_W'($urandom_range(255)),
                              1'($urandom_range(1)));
   endtask

   task automatic test_output_backpressure();
      set_idling(0, 0);
      wait_for_results();
      hold_rsp = 1'b1;
      repeat (5) begin
         send_command(KIND_FREE, INDEX_W'($urandom_range(255)), 1'b1);
         send_command(KIND_ALLOC, 8'd0, 1'b0);
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic(int unsigned send_pct, int unsigned stall_pct,
                                      logic [COUNT_W-1:0] size);
      int unsigned pick;
      int unsigned slot;
      logic [INDEX_W-1:0] index;
      write_block_count(size);
      set_idling(send_pct, stall_pct);
      send_command(KIND_INIT, INDEX_W'($urandom_range(255)), 1'($urandom_range(1)));
      for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
         if (n == RANDOM_PHASE_ITEMS / 2) wait_for_results();
         pick = $urandom_range(99);
         index = INDEX_W'($urandom_range(255));
         if (pick < 45) begin
            send_command(KIND_ALLOC, index, 1'($urandom_range(1)));
         end else if (pick < 80) begin
            // Mostly hand back a block that is really held.
            if (held_blocks.size() != 0) begin
               slot = $urandom_range(held_blocks.size() - 1);
               index = held_blocks[slot];
               held_blocks.delete(slot);
            end
            send_command(KIND_FREE, index, 1'b1);
         end else if (pick < 88) begin
            send_command(KIND_FREE, index, 1'b1);
         end else if (pick < 92) begin
            send_command(KIND_FREE, index, 1'b0);
         end else if (pick < 96) begin
            send_command(KIND_INIT, index, 1'($urandom_range(1)));
         end else begin
            send_command(KIND_UNUSED, index, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_small_pool();
      test_pool_extremes();
      test_count_saturation();
      test_output_backpressure();
      test_random_traffic(0, 0, 9'd16);
      test_random_traffic(48, 0, 9'd256);
      test_random_traffic(0, 48, 9'd2);
      test_random_traffic(28, 28, COUNT_W'($urandom_range(1, 256)));
      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
hdl/fbfl_pkg.sv
hdl/fixed_block_free_list_allocator.sv
dv/tb_fixed_block_free_list_allocator.sv
